// ----- hdl/xtgc_pkg.sv -----
// ----------------------------------------------------------------------------
// xtgc_pkg
// Shared types and constants for the xor trie greater-than counter.
// ----------------------------------------------------------------------------
package xtgc_pkg;

    localparam int KEY_BITS  = 31;
    localparam int NODE_POOL = 65536;
    localparam int NODE_W    = $clog2(NODE_POOL);
    localparam int FREE_W    = NODE_W + 1;
    localparam int LEVEL_W   = $clog2(KEY_BITS);
    localparam int CNT_W     = 32;
    localparam int BUDGET_W  = 31;

    typedef logic [NODE_W-1:0]           node_t;
    typedef logic [1:0][NODE_W-1:0]      links_t;
    typedef logic [CNT_W-1:0]            cnt_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_WALK,
        S_REM_CHK,
        S_REM_LEAF,
        S_REM_WALK,
        S_QRY_WALK,
        S_QRY_END,
        S_QRY_BUD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic   we;
        node_t  addr;
        links_t data;
    } link_wr_t;

    typedef struct packed {
        logic  we;
        node_t addr;
        cnt_t  data;
    } cnt_wr_t;

endpackage

// ----- hdl/xtgc_node_mem.sv -----
// ----------------------------------------------------------------------------
// xtgc_node_mem
// Node pool storage: child link pairs and per-node counts, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module xtgc_node_mem (
    input  logic               clk,
    input  xtgc_pkg::node_t    link_raddr,
    output xtgc_pkg::links_t   link_rd,
    input  xtgc_pkg::link_wr_t link_wr,
    input  xtgc_pkg::node_t    cnt_raddr,
    output xtgc_pkg::cnt_t     cnt_rd,
    input  xtgc_pkg::cnt_wr_t  cnt_wr
);
    import xtgc_pkg::*;

    links_t link_mem [NODE_POOL];
    cnt_t   cnt_mem  [NODE_POOL];

    always_ff @(posedge clk)
    begin
        if (link_wr.we)
        begin
            link_mem[link_wr.addr] <= link_wr.data;
        end
        link_rd <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_wr.we)
        begin
            cnt_mem[cnt_wr.addr] <= cnt_wr.data;
        end
        cnt_rd <= cnt_mem[cnt_raddr];
    end

endmodule

// ----- hdl/xor_trie_greater_count.sv -----
// ----------------------------------------------------------------------------
// xor_trie_greater_count
// Multiset of 31-bit keys in a binary trie; counts stored keys whose xor with
// a query key exceeds a threshold, with a miss budget.
// ----------------------------------------------------------------------------
// Usage:
// - item channel (item_valid / item_stall) carries operation, key, threshold;
//   the block takes one item at a time and holds item_stall high while busy.
// - result channel (result_valid / result_stall) gives one item per input
//   item from an output register; the next input item is taken while a
//   result still waits, and a finished item holds until the register frees.
// - budget channel (budget_valid / budget_ready) loads initial_budget into the
//   budget; ready only while idle.
// With the receiver not stalling, the result shows up in the same cycle as the
//   next item can be taken. The trie walk does one node memory access per level,
//   31 levels.
//   insert: one walk; when fewer than 31 nodes are free, a read-only walk
//   checks for room first, and the item is dropped when there is none.
//   query: one walk, shorter when the walk runs off the trie.
//   remove: check walk, leaf check, decrement walk; shorter when the key is
//   not stored.
// Reset: empty trie, next free node one, budget zero. Node memory needs no
//   clearing pass: nodes are written as they are allocated and entries above
//   the free pointer are never read.
// ----------------------------------------------------------------------------
module xor_trie_greater_count (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [1:0]                       operation,
    input  logic [xtgc_pkg::KEY_BITS-1:0]    key,
    input  logic [xtgc_pkg::KEY_BITS-1:0]    threshold,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [xtgc_pkg::CNT_W-1:0]       match_count,
    output logic signed [xtgc_pkg::CNT_W-1:0] budget_left,
    output logic                             pool_full,
    input  logic                             budget_valid,
    output logic                             budget_ready,
    input  logic [xtgc_pkg::BUDGET_W-1:0]    initial_budget
);
    import xtgc_pkg::*;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [KEY_BITS-1:0]   thr_reg, thr_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    node_t                 node_reg, node_next;
    logic                  new_reg, new_next;
    logic [FREE_W-1:0]     nf_reg, nf_next;
    links_t                root_reg, root_next;
    cnt_t                  acc_reg, acc_next;
    logic                  acc_pend_reg, acc_pend_next;
    logic                  full_reg, full_next;
    cnt_t                  budget_reg, budget_next;
    logic                  pend_reg, pend_next;
    logic                  pend_new_reg, pend_new_next;
    logic                  pend_dec_reg, pend_dec_next;
    node_t                 pend_addr_reg, pend_addr_next;
    logic                  result_valid_reg, result_valid_next;
    cnt_t                  match_reg, match_next;
    cnt_t                  budget_out_reg, budget_out_next;
    logic                  pool_full_reg, pool_full_next;

    links_t                links_cur;
    links_t                links_upd;
    logic                  bit_u;
    logic                  bit_v;
    node_t                 child;
    node_t                 other;
    node_t                 qry_next;
    logic                  last_level;
    logic [FREE_W:0]       need_sum;
    cnt_t                  alu_a;
    cnt_t                  alu_b;
    cnt_t                  alu_sum;

    node_t                 link_raddr;
    links_t                link_rd;
    link_wr_t              link_wr;
    node_t                 cnt_raddr;
    cnt_t                  cnt_rd;
    cnt_wr_t               cnt_wr;

    xtgc_node_mem u_node_mem (
        .clk        (clk),
        .link_raddr (link_raddr),
        .link_rd    (link_rd),
        .link_wr    (link_wr),
        .cnt_raddr  (cnt_raddr),
        .cnt_rd     (cnt_rd),
        .cnt_wr     (cnt_wr)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign budget_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign match_count  = match_reg;
    assign budget_left  = budget_out_reg;
    assign pool_full    = pool_full_reg;

    // root links live in flops, new nodes read as empty
    always_comb
    begin
        if (node_reg == '0)
        begin
            links_cur = root_reg;
        end
        else if (new_reg)
        begin
            links_cur = '0;
        end
        else
        begin
            links_cur = link_rd;
        end
    end

    assign bit_u      = key_reg[level_reg];
    assign bit_v      = thr_reg[level_reg];
    assign child      = links_cur[bit_u];
    assign other      = links_cur[!bit_u];
    assign qry_next   = bit_v ? other : child;
    assign last_level = (level_reg == '0);
    assign need_sum   = {1'b0, nf_reg} + (FREE_W+1)'(level_reg) + (FREE_W+1)'(1);

    always_comb
    begin
        links_upd        = links_cur;
        links_upd[bit_u] = nf_reg[NODE_W-1:0];
    end

    // shared adder: count update, query accumulate, budget decrement
    always_comb
    begin
        case (state_reg)
            S_QRY_WALK, S_QRY_END:
            begin
                alu_a = acc_reg;
                alu_b = cnt_rd;
            end
            S_QRY_BUD:
            begin
                alu_a = budget_reg;
                alu_b = '1;
            end
            default:
            begin
                alu_a = pend_new_reg ? '0 : cnt_rd;
                alu_b = pend_dec_reg ? '1 : CNT_W'(1);
            end
        endcase
        alu_sum = alu_a + alu_b;
    end

    assign cnt_wr.we   = pend_reg;
    assign cnt_wr.addr = pend_addr_reg;
    assign cnt_wr.data = alu_sum;

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        thr_next          = thr_reg;
        level_next        = level_reg;
        node_next         = node_reg;
        new_next          = new_reg;
        nf_next           = nf_reg;
        root_next         = root_reg;
        acc_next          = acc_reg;
        acc_pend_next     = 1'b0;
        full_next         = full_reg;
        budget_next       = budget_reg;
        pend_next         = 1'b0;
        pend_new_next     = pend_new_reg;
        pend_dec_next     = pend_dec_reg;
        pend_addr_next    = pend_addr_reg;
        result_valid_next = result_valid_reg && result_stall;
        match_next        = match_reg;
        budget_out_next   = budget_out_reg;
        pool_full_next    = pool_full_reg;
        link_raddr        = child;
        cnt_raddr         = child;
        link_wr.we        = 1'b0;
        link_wr.addr      = node_reg;
        link_wr.data      = links_upd;

        case (state_reg)
            S_IDLE:
            begin
                if (budget_valid)
                begin
                    budget_next = CNT_W'(initial_budget);
                end
                if (item_valid)
                begin
                    op_next    = op_t'(operation);
                    key_next   = key;
                    thr_next   = threshold;
                    node_next  = '0;
                    new_next   = 1'b0;
                    level_next = LEVEL_W'(KEY_BITS - 1);
                    acc_next   = '0;
                    full_next  = 1'b0;
                    case (op_t'(operation))
                        OP_INSERT:
                        begin
                            // room for a full path cannot run out, skip the check walk
                            if (nf_reg <= FREE_W'(NODE_POOL - KEY_BITS))
                            begin
                                state_next = S_INS_WALK;
                            end
                            else
                            begin
                                state_next = S_INS_CHK;
                            end
                        end
                        OP_REMOVE: state_next = S_REM_CHK;
                        OP_QUERY:  state_next = S_QRY_WALK;
                        default:   state_next = S_RESULT;
                    endcase
                end
            end

            S_INS_CHK:
            begin
                if (child == '0)
                begin
                    if (need_sum > (FREE_W+1)'(NODE_POOL))
                    begin
                        full_next  = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        node_next  = '0;
                        new_next   = 1'b0;
                        level_next = LEVEL_W'(KEY_BITS - 1);
                        state_next = S_INS_WALK;
                    end
                end
                else if (last_level)
                begin
                    node_next  = '0;
                    new_next   = 1'b0;
                    level_next = LEVEL_W'(KEY_BITS - 1);
                    state_next = S_INS_WALK;
                end
                else
                begin
                    node_next  = child;
                    level_next = level_reg - LEVEL_W'(1);
                end
            end

            S_INS_WALK:
            begin
                pend_next     = 1'b1;
                pend_dec_next = 1'b0;
                if (child == '0)
                begin
                    // allocate and hook into the parent
                    nf_next        = nf_reg + FREE_W'(1);
                    new_next       = 1'b1;
                    node_next      = nf_reg[NODE_W-1:0];
                    pend_new_next  = 1'b1;
                    pend_addr_next = nf_reg[NODE_W-1:0];
                    if (node_reg == '0)
                    begin
                        root_next = links_upd;
                    end
                    else
                    begin
                        link_wr.we = 1'b1;
                    end
                end
                else
                begin
                    new_next       = 1'b0;
                    node_next      = child;
                    pend_new_next  = 1'b0;
                    pend_addr_next = child;
                end
                if (last_level)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    level_next = level_reg - LEVEL_W'(1);
                end
            end

            S_REM_CHK:
            begin
                if (child == '0)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    node_next = child;
                    if (last_level)
                    begin
                        state_next = S_REM_LEAF;
                    end
                    else
                    begin
                        level_next = level_reg - LEVEL_W'(1);
                    end
                end
            end

            S_REM_LEAF:
            begin
                if (cnt_rd != '0)
                begin
                    node_next  = '0;
                    new_next   = 1'b0;
                    level_next = LEVEL_W'(KEY_BITS - 1);
                    state_next = S_REM_WALK;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_REM_WALK:
            begin
                node_next      = child;
                pend_next      = 1'b1;
                pend_new_next  = 1'b0;
                pend_dec_next  = 1'b1;
                pend_addr_next = child;
                if (last_level)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    level_next = level_reg - LEVEL_W'(1);
                end
            end

            S_QRY_WALK:
            begin
                if (acc_pend_reg)
                begin
                    acc_next = alu_sum;
                end
                // subtree on the other side all exceeds the threshold here
                if (!bit_v && other != '0)
                begin
                    cnt_raddr     = other;
                    acc_pend_next = 1'b1;
                end
                link_raddr = qry_next;
                if (qry_next == '0 || last_level)
                begin
                    state_next = S_QRY_END;
                end
                else
                begin
                    node_next  = qry_next;
                    level_next = level_reg - LEVEL_W'(1);
                end
            end

            S_QRY_END:
            begin
                if (acc_pend_reg)
                begin
                    acc_next = alu_sum;
                end
                state_next = S_QRY_BUD;
            end

            S_QRY_BUD:
            begin
                if (acc_reg == '0)
                begin
                    budget_next = alu_sum;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    match_next        = acc_reg;
                    budget_out_next   = budget_reg;
                    pool_full_next    = full_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            nf_reg           <= FREE_W'(1);
            root_reg         <= '0;
            budget_reg       <= '0;
            result_valid_reg <= 1'b0;
            pend_reg         <= 1'b0;
            acc_pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            nf_reg           <= nf_next;
            root_reg         <= root_next;
            budget_reg       <= budget_next;
            result_valid_reg <= result_valid_next;
            pend_reg         <= pend_next;
            acc_pend_reg     <= acc_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        thr_reg        <= thr_next;
        level_reg      <= level_next;
        node_reg       <= node_next;
        new_reg        <= new_next;
        acc_reg        <= acc_next;
        full_reg       <= full_next;
        pend_new_reg   <= pend_new_next;
        pend_dec_reg   <= pend_dec_next;
        pend_addr_reg  <= pend_addr_next;
        match_reg      <= match_next;
        budget_out_reg <= budget_out_next;
        pool_full_reg  <= pool_full_next;
    end

    a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg != '0) && (nf_reg <= FREE_W'(NODE_POOL)))
        else $error("free node pointer out of range");

    a_alloc_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_WALK && child == '0) |-> (nf_reg < FREE_W'(NODE_POOL)))
        else $error("node allocated beyond the pool");

    a_cnt_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_wr.we |-> (state_reg == S_INS_WALK || state_reg == S_REM_WALK ||
                       state_reg == S_RESULT))
        else $error("count write outside an update walk");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_RESULT))
        else $error("result raised outside the result state");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && full_reg) |-> (op_reg == OP_INSERT))
        else $error("pool full flagged on a non-insert item");

endmodule
